FILE: design/rhsv_pkg.sv
package rhsv_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned HueW        = 15;
  localparam int unsigned SatW        = 17;
  localparam int unsigned HueQuoW     = 12;
  localparam int unsigned HueNumW     = 20;
  localparam int unsigned DivSteps    = SatW;
  localparam int unsigned StepW       = $clog2(DivSteps);
  localparam int unsigned SectorUnits = 3840;
  localparam int unsigned FullTurn    = 23040;
  localparam int unsigned SatOne      = 65536;

  typedef enum logic [1:0] {
    SectRed,
    SectGreen,
    SectBlue
  } sector_e;

  // One pixel on its way through the divider stages.
  typedef struct packed {
    logic [ChanW-1:0]   hi;
    logic [ChanW-1:0]   delta;
    logic               neg;
    sector_e            sector;
    logic [ChanW-1:0]   sat_rem;
    logic               sat_bit;
    logic [SatW-1:0]    sat_quo;
    logic [ChanW-1:0]   hue_rem;
    logic [HueQuoW-1:0] hue_low;
    logic [HueQuoW-1:0] hue_quo;
  } div_word_t;

endpackage

FILE: design/rhsv_front.sv
module rhsv_front (
  input  logic [rhsv_pkg::ChanW-1:0] red_i,
  input  logic [rhsv_pkg::ChanW-1:0] green_i,
  input  logic [rhsv_pkg::ChanW-1:0] blue_i,
  output rhsv_pkg::div_word_t        word_o
);

  logic [rhsv_pkg::ChanW-1:0]   hi;
  logic [rhsv_pkg::ChanW-1:0]   lo;
  logic [rhsv_pkg::ChanW-1:0]   delta;
  logic signed [rhsv_pkg::ChanW:0] diff;
  logic [rhsv_pkg::ChanW:0]     diff_abs;
  logic [rhsv_pkg::ChanW-1:0]   mag;
  logic [rhsv_pkg::HueNumW-1:0] num;
  rhsv_pkg::sector_e            sector;

  always_comb begin
    hi = (red_i >= green_i) ? red_i : green_i;
    if (blue_i > hi) begin
      hi = blue_i;
    end
    lo = (red_i <= green_i) ? red_i : green_i;
    if (blue_i < lo) begin
      lo = blue_i;
    end
    delta = hi - lo;

    // Ties go to red first, then green.
    if (red_i == hi) begin
      sector = rhsv_pkg::SectRed;
      diff   = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == hi) begin
      sector = rhsv_pkg::SectGreen;
      diff   = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sector = rhsv_pkg::SectBlue;
      diff   = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end

    diff_abs = diff[rhsv_pkg::ChanW] ? (~diff + 1'b1) : diff;
    mag      = diff_abs[rhsv_pkg::ChanW-1:0];
    // 3840 is 4096 - 256.
    num      = {mag, 12'b0} - {4'b0, mag, 8'b0};

    word_o.hi      = hi;
    word_o.delta   = delta;
    word_o.neg     = diff[rhsv_pkg::ChanW];
    word_o.sector  = sector;
    word_o.sat_rem = {1'b0, delta[rhsv_pkg::ChanW-1:1]};
    word_o.sat_bit = delta[0];
    word_o.sat_quo = '0;
    word_o.hue_rem = num[rhsv_pkg::HueNumW-1:rhsv_pkg::HueQuoW];
    word_o.hue_low = num[rhsv_pkg::HueQuoW-1:0];
    word_o.hue_quo = '0;
  end

endmodule

FILE: design/rhsv_div_step.sv
module rhsv_div_step (
  input  rhsv_pkg::div_word_t         word_i,
  input  logic [rhsv_pkg::StepW-1:0]  step_i,
  output rhsv_pkg::div_word_t         word_o
);

  logic [rhsv_pkg::ChanW:0] sat_t;
  logic [rhsv_pkg::ChanW:0] hue_t;
  logic                     sat_ge;
  logic                     hue_ge;

  always_comb begin
    word_o = word_i;

    // Saturation: one restoring step, divisor is the maximum channel.
    sat_t  = {word_i.sat_rem, word_i.sat_bit};
    sat_ge = sat_t >= {1'b0, word_i.hi};
    word_o.sat_rem = sat_ge ? rhsv_pkg::ChanW'(sat_t - {1'b0, word_i.hi})
                            : sat_t[rhsv_pkg::ChanW-1:0];
    word_o.sat_bit = 1'b0;
    word_o.sat_quo = {word_i.sat_quo[rhsv_pkg::SatW-2:0], sat_ge};

    // Hue: the quotient is shorter, so it finishes in the earlier stages.
    hue_t  = {word_i.hue_rem, word_i.hue_low[rhsv_pkg::HueQuoW-1]};
    hue_ge = hue_t >= {1'b0, word_i.delta};
    if (step_i < rhsv_pkg::StepW'(rhsv_pkg::HueQuoW)) begin
      word_o.hue_rem = hue_ge ? rhsv_pkg::ChanW'(hue_t - {1'b0, word_i.delta})
                              : hue_t[rhsv_pkg::ChanW-1:0];
      word_o.hue_low = {word_i.hue_low[rhsv_pkg::HueQuoW-2:0], 1'b0};
      word_o.hue_quo = {word_i.hue_quo[rhsv_pkg::HueQuoW-2:0], hue_ge};
    end
  end

endmodule

FILE: design/rhsv_back.sv
module rhsv_back (
  input  rhsv_pkg::div_word_t        word_i,
  output logic [rhsv_pkg::HueW-1:0]  hue_o,
  output logic [rhsv_pkg::SatW-1:0]  saturation_o,
  output logic [rhsv_pkg::ChanW-1:0] brightness_o
);

  logic signed [15:0] quo_s;
  logic signed [15:0] base;
  logic signed [15:0] sum;

  always_comb begin
    quo_s = $signed({4'b0, word_i.hue_quo});
    if (word_i.neg) begin
      quo_s = -quo_s;
    end

    unique case (word_i.sector)
      rhsv_pkg::SectRed:   base = 16'sd0;
      rhsv_pkg::SectGreen: base = 16'(2 * rhsv_pkg::SectorUnits);
      rhsv_pkg::SectBlue:  base = 16'(4 * rhsv_pkg::SectorUnits);
      default:             base = 16'sd0;
    endcase

    sum = base + quo_s;
    if (sum < 0) begin
      sum = sum + 16'(rhsv_pkg::FullTurn);
    end

    // A grey or black pixel has no hue.
    hue_o        = (word_i.delta == '0) ? '0 : sum[rhsv_pkg::HueW-1:0];
    saturation_o = (word_i.hi == '0) ? '0 : word_i.sat_quo;
    brightness_o = word_i.hi;
  end

endmodule

FILE: design/rgb_to_hsv_converter_top.sv
// RGB to HSV converter. Each accepted word is one 8-bit red, green, blue pixel and yields
// exactly one result word: brightness is the largest channel, saturation is
// (max - min) / max as a 17-bit fraction where 65536 means 1.0 (truncated, 0 for a black
// pixel), and hue is in 1/64-degree units from 0 to 23039 (0 for a grey pixel). The
// converter takes a new pixel every clock cycle while stall_o is low, and results leave in
// input order. The edge that accepts a pixel loads the front stage, which holds the extremes
// and sector, then the word crosses 17 restoring divider stages that each produce one
// saturation quotient bit (the 12-bit hue quotient is formed in the first twelve of them)
// and lands in the output register. Every stage holds a valid bit and moves on whenever the
// stage after it is empty or moving, so holding stall_i only stalls the input side once
// every stage is full.
module rgb_to_hsv_converter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [rhsv_pkg::ChanW-1:0]  red_i,
  input  logic [rhsv_pkg::ChanW-1:0]  green_i,
  input  logic [rhsv_pkg::ChanW-1:0]  blue_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [rhsv_pkg::HueW-1:0]   hue_o,
  output logic [rhsv_pkg::SatW-1:0]   saturation_o,
  output logic [rhsv_pkg::ChanW-1:0]  brightness_o
);

  localparam int unsigned Last = rhsv_pkg::DivSteps;

  // Stage 0 holds the front result, stage k the word after k divider steps.
  rhsv_pkg::div_word_t word_q [Last+1];
  rhsv_pkg::div_word_t step_out [Last];
  rhsv_pkg::div_word_t front_word;
  logic [Last:0]       vld_q;
  logic [Last:0]       vld_d;
  logic [Last+1:0]     ld;

  logic                       out_vld_q;
  logic                       out_vld_d;
  logic [rhsv_pkg::HueW-1:0]  hue_q;
  logic [rhsv_pkg::HueW-1:0]  hue_d;
  logic [rhsv_pkg::SatW-1:0]  sat_q;
  logic [rhsv_pkg::SatW-1:0]  sat_d;
  logic [rhsv_pkg::ChanW-1:0] bright_q;
  logic [rhsv_pkg::ChanW-1:0] bright_d;

  rhsv_front u_front (
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .word_o  (front_word)
  );

  for (genvar k = 0; k < Last; k++) begin : g_step
    rhsv_div_step u_step (
      .word_i (word_q[k]),
      .step_i (rhsv_pkg::StepW'(k)),
      .word_o (step_out[k])
    );
  end

  rhsv_back u_back (
    .word_i       (word_q[Last]),
    .hue_o        (hue_d),
    .saturation_o (sat_d),
    .brightness_o (bright_d)
  );

  // A stage may load when it is empty or when its own word moves on.
  always_comb begin
    ld[Last+1] = !out_vld_q || !stall_i;
    for (int k = Last; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
    vld_d[0] = ld[0] ? valid_i : vld_q[0];
    for (int k = 1; k <= Last; k++) begin
      vld_d[k] = ld[k] ? vld_q[k-1] : vld_q[k];
    end
    out_vld_d = ld[Last+1] ? vld_q[Last] : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      word_q[0] <= front_word;
    end
    for (int k = 1; k <= Last; k++) begin
      if (ld[k]) begin
        word_q[k] <= step_out[k-1];
      end
    end
    if (ld[Last+1]) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= bright_d;
    end
  end

  assign stall_o      = !ld[0];
  assign valid_o      = out_vld_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> ((&vld_q) && out_vld_q && stall_i))
    else $error("input stalled while a stage was free");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hue_o < rhsv_pkg::HueW'(rhsv_pkg::FullTurn)))
    else $error("hue beyond a full turn");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (saturation_o <= rhsv_pkg::SatW'(rhsv_pkg::SatOne)))
    else $error("saturation above one");

  a_black_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (brightness_o == '0)) |-> ((saturation_o == '0) && (hue_o == '0)))
    else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
